FILE: hdl/hslrgb_pkg.sv
// Shared types and constants for the HSL to RGB converter.
`default_nettype none

package hslrgb_pkg;

    localparam int HUE_BITS_DEFAULT = 12;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_INDEX_W      = 2;
    localparam int CHROMA_W         = 25;
    localparam int QUEUE_DEPTH      = 2;
    localparam int SECTOR_W         = 3;

    localparam logic [CFG_DATA_W-1:0] Q_ONE           = 13'd4096;
    localparam logic [CFG_DATA_W-1:0] REG_RESET_VALUE = 13'd2048;

    localparam logic [CFG_INDEX_W-1:0] REG_SATURATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHTNESS  = 2'd1;

    typedef logic [SECTOR_W-1:0] sector_t;

    // Hue sectors, named by the colors they run between.
    localparam sector_t SEC_RED_YELLOW    = 3'd0;
    localparam sector_t SEC_YELLOW_GREEN  = 3'd1;
    localparam sector_t SEC_GREEN_CYAN    = 3'd2;
    localparam sector_t SEC_CYAN_BLUE     = 3'd3;
    localparam sector_t SEC_BLUE_MAGENTA  = 3'd4;
    localparam sector_t SEC_MAGENTA_RED   = 3'd5;

    // Terms that follow from the configuration registers alone.
    typedef struct packed {
        logic [CHROMA_W-1:0]   chroma;
        logic [CFG_DATA_W-1:0] light;
    } color_terms_t;

endpackage

`default_nettype wire

FILE: hdl/hslrgb_front.sv
// Front end: configuration registers, chroma term and hue sector classification.
`default_nettype none

module hslrgb_front #(
    parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [hslrgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hslrgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [HUE_BITS-1:0]                 hue,
    output hslrgb_pkg::sector_t                      sector,
    output logic [HUE_BITS:0]                        weight,
    output hslrgb_pkg::color_terms_t                 terms
);

    localparam int DW = hslrgb_pkg::CFG_DATA_W;
    localparam int H6W = HUE_BITS + 3;

    logic [DW-1:0] sat_reg;
    logic [DW-1:0] light_reg;
    logic [hslrgb_pkg::CHROMA_W-1:0] chroma_reg;
    logic [hslrgb_pkg::CHROMA_W-1:0] chroma_next;

    logic [DW-1:0] sat_c;
    logic [DW-1:0] light_c;
    logic [DW:0]   two_light;
    logic [DW:0]   dev;
    logic [DW-1:0] tval;
    logic [2*DW-1:0] prod;
    logic [H6W-1:0] h6;
    logic [HUE_BITS-1:0] frac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= hslrgb_pkg::REG_RESET_VALUE;
            light_reg <= hslrgb_pkg::REG_RESET_VALUE;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == hslrgb_pkg::REG_SATURATION)
            begin
                sat_reg <= cfg_data;
            end
            else if (cfg_index == hslrgb_pkg::REG_LIGHTNESS)
            begin
                light_reg <= cfg_data;
            end
        end
    end

    // Registered chroma; users must change registers only while idle, unchecked.
    always_comb
    begin
        sat_c     = (sat_reg > hslrgb_pkg::Q_ONE) ? hslrgb_pkg::Q_ONE : sat_reg;
        light_c   = (light_reg > hslrgb_pkg::Q_ONE) ? hslrgb_pkg::Q_ONE : light_reg;
        two_light = {light_c, 1'b0};
        if (two_light >= {1'b0, hslrgb_pkg::Q_ONE})
        begin
            dev = two_light - {1'b0, hslrgb_pkg::Q_ONE};
        end
        else
        begin
            dev = {1'b0, hslrgb_pkg::Q_ONE} - two_light;
        end
        tval        = hslrgb_pkg::Q_ONE - dev[DW-1:0];
        prod        = tval * sat_c;
        chroma_next = prod[hslrgb_pkg::CHROMA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        chroma_reg <= chroma_next;
    end

    assign terms.chroma = chroma_reg;
    assign terms.light  = light_c;

    // Six times the hue: the top bits give the sector, the rest the fraction.
    always_comb
    begin
        h6     = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        sector = h6[H6W-1:HUE_BITS];
        frac   = h6[HUE_BITS-1:0];
        if (sector[0])
        begin
            weight = ((HUE_BITS+1)'(1) << HUE_BITS) - {1'b0, frac};
        end
        else
        begin
            weight = {1'b0, frac};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hslrgb_queue.sv
// Small request queue between the front end and the arithmetic back end.
`default_nettype none

module hslrgb_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = hslrgb_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/hslrgb_back.sv
// Back end: second component, lightness offset and scaling to 8-bit channels.
`default_nettype none

module hslrgb_back #(
    parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire hslrgb_pkg::sector_t      sector,
    input  wire logic [HUE_BITS:0]        weight,
    input  wire hslrgb_pkg::color_terms_t terms,
    output logic                          done,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue
);

    localparam int CHW   = hslrgb_pkg::CHROMA_W;
    localparam int VW    = CHW + HUE_BITS;
    localparam int SHIFT = 24 + HUE_BITS;
    localparam int SW    = VW + 8;
    localparam int QW    = SW - SHIFT;
    localparam int PRW   = CHW + HUE_BITS + 1;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic done_reg;
    hslrgb_pkg::sector_t s1_sector_reg;
    logic [VW-1:0] s1_x_reg;
    logic [VW-1:0] s1_cs_reg;
    logic [VW-1:0] s1_m_reg;
    logic [VW-1:0] v_r_reg;
    logic [VW-1:0] v_g_reg;
    logic [VW-1:0] v_b_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    logic [PRW-1:0] x_prod;
    logic [VW-1:0] m_next;
    logic [VW-1:0] comp_r;
    logic [VW-1:0] comp_g;
    logic [VW-1:0] comp_b;

    function automatic logic [7:0] to_byte(input logic [VW-1:0] v);
        logic [SW-1:0] scaled;
        logic [QW-1:0] q;
        begin
            scaled = (SW'(v) << 8) - SW'(v) + (SW'(1) << (SHIFT - 1));
            q      = scaled[SW-1:SHIFT];
            to_byte = (q > QW'(255)) ? 8'd255 : q[7:0];
        end
    endfunction

    // Stage 1: second component and the common offset L - C/2.
    always_comb
    begin
        x_prod = terms.chroma * weight;
        m_next = (VW'(terms.light) << (12 + HUE_BITS))
               - (VW'(terms.chroma) << (HUE_BITS - 1));
    end

    // Stage 2: place the components by sector.
    always_comb
    begin
        comp_r = '0;
        comp_g = '0;
        comp_b = '0;
        case (s1_sector_reg)
            hslrgb_pkg::SEC_RED_YELLOW:
            begin
                comp_r = s1_cs_reg;
                comp_g = s1_x_reg;
            end
            hslrgb_pkg::SEC_YELLOW_GREEN:
            begin
                comp_r = s1_x_reg;
                comp_g = s1_cs_reg;
            end
            hslrgb_pkg::SEC_GREEN_CYAN:
            begin
                comp_g = s1_cs_reg;
                comp_b = s1_x_reg;
            end
            hslrgb_pkg::SEC_CYAN_BLUE:
            begin
                comp_g = s1_x_reg;
                comp_b = s1_cs_reg;
            end
            hslrgb_pkg::SEC_BLUE_MAGENTA:
            begin
                comp_r = s1_x_reg;
                comp_b = s1_cs_reg;
            end
            hslrgb_pkg::SEC_MAGENTA_RED:
            begin
                comp_r = s1_cs_reg;
                comp_b = s1_x_reg;
            end
            default:
            begin
                comp_r = s1_cs_reg;
                comp_b = s1_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sector_reg <= sector;
        s1_x_reg      <= x_prod[VW-1:0];
        s1_cs_reg     <= VW'(terms.chroma) << HUE_BITS;
        s1_m_reg      <= m_next;
        v_r_reg       <= comp_r + s1_m_reg;
        v_g_reg       <= comp_g + s1_m_reg;
        v_b_reg       <= comp_b + s1_m_reg;
        red_reg       <= to_byte(v_r_reg);
        green_reg     <= to_byte(v_g_reg);
        blue_reg      <= to_byte(v_b_reg);
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

FILE: hdl/hsl_to_rgb_converter_core.sv
// Top level of the HSL to RGB converter: front end, request queue and back end.
//
//  channel   signals                                   direction
//  request   start, busy, hue                          in (busy out)
//  result    done, red, green, blue                    out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// One hue is taken per clock while busy is low; each result appears on done after
// its request is accepted and has passed through the queue and three back-end stages.
// The back end drains the queue every cycle, so busy stays low in normal use.
// Reset returns saturation and lightness to one half and empties the pipeline.
// Results cannot be held off by the receiver; done lasts exactly one cycle.
`default_nettype none

module hsl_to_rgb_converter_core #(
    parameter int HUE_BITS = hslrgb_pkg::HUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [HUE_BITS-1:0]                 hue,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hslrgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hslrgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                     done,
    output logic [7:0]                               red,
    output logic [7:0]                               green,
    output logic [7:0]                               blue
);

    localparam int EW = hslrgb_pkg::SECTOR_W + HUE_BITS + 1;

    hslrgb_pkg::sector_t      front_sector;
    logic [HUE_BITS:0]        front_weight;
    hslrgb_pkg::color_terms_t terms;
    logic [EW-1:0]            q_out;
    logic                     q_empty;
    logic                     q_full;
    logic                     accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign accept    = start && !busy;

    hslrgb_front #(
        .HUE_BITS (HUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hue       (hue),
        .sector    (front_sector),
        .weight    (front_weight),
        .terms     (terms)
    );

    hslrgb_queue #(
        .WIDTH (EW),
        .DEPTH (hslrgb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({front_sector, front_weight}),
        .pop       (!q_empty),
        .pop_data  (q_out),
        .empty     (q_empty),
        .full      (q_full)
    );

    hslrgb_back #(
        .HUE_BITS (HUE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .sector   (q_out[EW-1:HUE_BITS+1]),
        .weight   (q_out[HUE_BITS:0]),
        .terms    (terms),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

`ifndef ASSERT_OFF
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("request queue filled up");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted request produced no result");

    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        terms.chroma <= (hslrgb_pkg::CHROMA_W'(1) << 24))
        else $error("chroma above one");
`endif

endmodule

`default_nettype wire
